// File: rtl/mfa_pkg.sv
// Shared types and constants of the mixed fraction ALU.
// Used by the channel interfaces, the controller, the datapath and the top level.
package mfa_pkg;

   localparam int VALUE_WIDTH_DEF = 32;
   localparam int WORD_W = 32;
   localparam int DEN_W = 31;
   localparam int ACT_W = 3;
   localparam int ST_W = 2;
   localparam int MAG_W = 64;
   localparam int WIDE_W = 128;
   localparam int CNT_W = 7;

   localparam logic [ACT_W-1:0] ACT_ADD = 3'd0;
   localparam logic [ACT_W-1:0] ACT_SUB = 3'd1;
   localparam logic [ACT_W-1:0] ACT_MUL = 3'd2;
   localparam logic [ACT_W-1:0] ACT_DIV = 3'd3;
   localparam logic [ACT_W-1:0] ACT_NORM = 3'd4;

   localparam logic [ST_W-1:0] ST_OK = 2'd0;
   localparam logic [ST_W-1:0] ST_ZERO_ZERO = 2'd1;
   localparam logic [ST_W-1:0] ST_ZERO_DEN = 2'd2;
   localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd3;

   typedef enum logic [2:0] {
      MS_OPA = 3'd0,
      MS_OPB = 3'd1,
      MS_P1 = 3'd2,
      MS_P2 = 3'd3,
      MS_P3 = 3'd4
   } mul_sel_type;

   typedef enum logic [1:0] {
      DS_NG = 2'd0,
      DS_DG = 2'd1,
      DS_ND = 2'd2
   } div_sel_type;

   typedef struct packed {
      logic load;
      logic mul_start;
      mul_sel_type mul_sel;
      logic combine;
      logic gcd_start;
      logic div_start;
      div_sel_type div_sel;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic err;
      logic mul_done;
      logic gcd_done;
      logic div_done;
   } sts_type;

endpackage

// File: rtl/mfa_channels.sv
// Valid/ready channel interfaces for the request and response words.
// Depends on mfa_pkg for the field widths.
interface mfa_req_if;
   import mfa_pkg::*;
   logic valid;
   logic ready;
   logic [ACT_W-1:0] action;
   logic signed [WORD_W-1:0] a_whole;
   logic signed [WORD_W-1:0] a_num;
   logic signed [WORD_W-1:0] a_den;
   logic signed [WORD_W-1:0] b_whole;
   logic signed [WORD_W-1:0] b_num;
   logic [DEN_W-1:0] b_den;
   modport source (output valid, action, a_whole, a_num, a_den, b_whole, b_num, b_den,
                   input ready);
   modport sink (input valid, action, a_whole, a_num, a_den, b_whole, b_num, b_den,
                 output ready);
endinterface

interface mfa_rsp_if;
   import mfa_pkg::*;
   logic valid;
   logic ready;
   logic signed [WORD_W-1:0] res_whole;
   logic signed [WORD_W-1:0] res_num;
   logic [DEN_W-1:0] res_den;
   logic [ST_W-1:0] status;
   modport source (output valid, res_whole, res_num, res_den, status, input ready);
   modport sink (input valid, res_whole, res_num, res_den, status, output ready);
endinterface

// File: rtl/mfa_controller.sv
// Sequencing state machine of the mixed fraction ALU.
// Depends on mfa_pkg; drives the datapath through cmd_type and reads sts_type.
module mfa_controller (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input logic rsp_ready,
   output mfa_pkg::cmd_type cmd,
   input mfa_pkg::sts_type sts
);
   import mfa_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_MUL_GO = 9'b000000010,
      S_MUL_WAIT = 9'b000000100,
      S_COMB = 9'b000001000,
      S_GCD_GO = 9'b000010000,
      S_GCD_WAIT = 9'b000100000,
      S_DIV_GO = 9'b001000000,
      S_DIV_WAIT = 9'b010000000,
      S_OUT = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   mul_sel_type mul_sel_ff, mul_sel_in;
   div_sel_type div_sel_ff, div_sel_in;
   logic rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      mul_sel_in = mul_sel_ff;
      div_sel_in = div_sel_ff;
      cmd = '0;
      cmd.mul_sel = mul_sel_ff;
      cmd.div_sel = div_sel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               mul_sel_in = MS_OPA;
               state_in = S_MUL_GO;
            end
         end
         S_MUL_GO: begin
            if (sts.err) begin
               state_in = S_OUT;
            end else begin
               cmd.mul_start = 1'b1;
               state_in = S_MUL_WAIT;
            end
         end
         S_MUL_WAIT: begin
            if (sts.mul_done) begin
               case (mul_sel_ff)
                  MS_OPA: begin
                     mul_sel_in = MS_OPB;
                     state_in = S_MUL_GO;
                  end
                  MS_OPB: begin
                     mul_sel_in = MS_P1;
                     state_in = S_MUL_GO;
                  end
                  MS_P1: begin
                     mul_sel_in = MS_P2;
                     state_in = S_MUL_GO;
                  end
                  MS_P2: begin
                     mul_sel_in = MS_P3;
                     state_in = S_MUL_GO;
                  end
                  default: begin
                     state_in = S_COMB;
                  end
               endcase
            end
         end
         S_COMB: begin
            cmd.combine = 1'b1;
            state_in = S_GCD_GO;
         end
         S_GCD_GO: begin
            if (sts.err) begin
               state_in = S_OUT;
            end else begin
               cmd.gcd_start = 1'b1;
               state_in = S_GCD_WAIT;
            end
         end
         S_GCD_WAIT: begin
            if (sts.gcd_done) begin
               div_sel_in = DS_NG;
               state_in = S_DIV_GO;
            end
         end
         S_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (sts.div_done) begin
               case (div_sel_ff)
                  DS_NG: begin
                     div_sel_in = DS_DG;
                     state_in = S_DIV_GO;
                  end
                  DS_DG: begin
                     div_sel_in = DS_ND;
                     state_in = S_DIV_GO;
                  end
                  default: begin
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mul_sel_ff <= MS_OPA;
         div_sel_ff <= DS_NG;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mul_sel_ff <= mul_sel_in;
         div_sel_ff <= div_sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/mfa_datapath.sv
// Datapath of the mixed fraction ALU: operand registers, a shared 32x32 multiplier,
// a binary GCD unit and a restoring divider. Depends on mfa_pkg.
module mfa_datapath #(
   parameter int VALUE_WIDTH = mfa_pkg::VALUE_WIDTH_DEF
) (
   input logic clock,
   input logic reset,
   input mfa_pkg::cmd_type cmd,
   output mfa_pkg::sts_type sts,
   input logic [mfa_pkg::ACT_W-1:0] action,
   input logic signed [mfa_pkg::WORD_W-1:0] a_whole,
   input logic signed [mfa_pkg::WORD_W-1:0] a_num,
   input logic signed [mfa_pkg::WORD_W-1:0] a_den,
   input logic signed [mfa_pkg::WORD_W-1:0] b_whole,
   input logic signed [mfa_pkg::WORD_W-1:0] b_num,
   input logic [mfa_pkg::DEN_W-1:0] b_den,
   output logic signed [mfa_pkg::WORD_W-1:0] res_whole,
   output logic signed [mfa_pkg::WORD_W-1:0] res_num,
   output logic [mfa_pkg::DEN_W-1:0] res_den,
   output logic [mfa_pkg::ST_W-1:0] status
);
   import mfa_pkg::*;

   localparam logic [WIDE_W-1:0] LIM = (WIDE_W'(1) << (VALUE_WIDTH - 1)) - WIDE_W'(1);

   typedef enum logic [3:0] {
      G_IDLE = 4'b0001,
      G_COMMON = 4'b0010,
      G_AEVEN = 4'b0100,
      G_LOOP = 4'b1000
   } gcd_phase_type;

   function automatic logic [WORD_W-1:0] mag(input logic [WORD_W-1:0] v);
      mag = v[WORD_W-1] ? (~v + WORD_W'(1)) : v;
   endfunction

   // Operand registers.
   logic [ACT_W-1:0] act_ff;
   logic [WORD_W-1:0] a_wm_ff, a_nm_ff, a_dm_ff, b_wm_ff, b_nm_ff, b_dm_ff;
   logic a_neg_ff, b_neg_ff;
   logic [ST_W-1:0] status_ff;
   logic [WORD_W-1:0] a_wm_in, a_nm_in, a_dm_in, b_wm_in, b_nm_in, b_dm_in;
   logic [ST_W-1:0] a_st, b_st, load_st;
   logic a_neg_in, b_neg_in;

   always_comb begin
      a_wm_in = mag(a_whole);
      a_nm_in = mag(a_num);
      a_dm_in = mag(a_den);
      b_wm_in = mag(b_whole);
      b_nm_in = mag(b_num);
      b_dm_in = {1'b0, b_den};
      a_neg_in = ((a_wm_in != '0) ? (a_whole[WORD_W-1] | a_num[WORD_W-1]) : a_num[WORD_W-1])
                 ^ a_den[WORD_W-1];
      b_neg_in = (b_wm_in != '0) ? (b_whole[WORD_W-1] | b_num[WORD_W-1]) : b_num[WORD_W-1];
      a_st = ST_OK;
      if (a_dm_in == '0) begin
         a_st = (a_wm_in == '0 && a_nm_in == '0) ? ST_ZERO_ZERO : ST_ZERO_DEN;
      end
      b_st = ST_OK;
      if (b_dm_in == '0) begin
         b_st = (b_wm_in == '0 && b_nm_in == '0) ? ST_ZERO_ZERO : ST_ZERO_DEN;
      end
      load_st = a_st;
      if (a_st == ST_OK && (action inside {ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV})) begin
         load_st = b_st;
      end
   end

   // Shared multiplier: a 64 by 64 product as four 32 by 32 partial products.
   logic [MAG_W-1:0] a_mag_ff, b_mag_ff;
   logic [WIDE_W-1:0] x_ff, y_ff, z_ff;
   logic [MAG_W-1:0] op1_ff, op2_ff, op1_in, op2_in;
   logic [WIDE_W-1:0] acc_ff, acc_in;
   logic [1:0] step_ff;
   logic mul_busy_ff, mul_done_ff;
   mul_sel_type msel_ff;
   logic [WORD_W-1:0] m1, m2;
   logic [2*WORD_W-1:0] pp;
   logic [1:0] sh;

   always_comb begin
      case (cmd.mul_sel)
         MS_OPA: begin
            op1_in = MAG_W'(a_wm_ff);
            op2_in = MAG_W'(a_dm_ff);
         end
         MS_OPB: begin
            op1_in = MAG_W'(b_wm_ff);
            op2_in = MAG_W'(b_dm_ff);
         end
         MS_P1: begin
            op1_in = a_mag_ff;
            op2_in = (act_ff == ACT_MUL) ? b_mag_ff : MAG_W'(b_dm_ff);
         end
         MS_P2: begin
            op1_in = b_mag_ff;
            op2_in = MAG_W'(a_dm_ff);
         end
         default: begin
            op1_in = MAG_W'(a_dm_ff);
            op2_in = MAG_W'(b_dm_ff);
         end
      endcase
      m1 = step_ff[1] ? op1_ff[MAG_W-1:WORD_W] : op1_ff[WORD_W-1:0];
      m2 = step_ff[0] ? op2_ff[MAG_W-1:WORD_W] : op2_ff[WORD_W-1:0];
      pp = m1 * m2;
      sh = {1'b0, step_ff[1]} + {1'b0, step_ff[0]};
      acc_in = acc_ff + (WIDE_W'(pp) << {sh, 5'd0});
   end

   // Combine step.
   logic [WIDE_W-1:0] n_ff, d_ff, g_ff, q_ff, r_ff;
   logic neg_ff;
   logic [WIDE_W:0] diff;
   logic yneg;

   assign diff = {1'b0, x_ff} - {1'b0, y_ff};
   assign yneg = (act_ff == ACT_SUB) ? !b_neg_ff : b_neg_ff;

   // GCD unit.
   gcd_phase_type gph_ff;
   logic [WIDE_W-1:0] ga_ff, gb_ff;
   logic [CNT_W-1:0] k_ff;
   logic gcd_done_ff;
   logic [WIDE_W:0] gdiff;

   assign gdiff = {1'b0, gb_ff} - {1'b0, ga_ff};

   // Restoring divider, one quotient bit per cycle.
   logic [WIDE_W-1:0] dvd_ff, dvs_ff, rr_ff, qq_ff, dvd_in, dvs_in, rr_in, qq_in, rr_sh;
   logic [WIDE_W:0] dsub;
   logic [CNT_W-1:0] cnt_ff;
   logic div_busy_ff, div_done_ff;
   div_sel_type dsel_ff;

   always_comb begin
      case (cmd.div_sel)
         DS_NG: begin
            dvd_in = n_ff;
            dvs_in = g_ff;
         end
         DS_DG: begin
            dvd_in = d_ff;
            dvs_in = g_ff;
         end
         default: begin
            dvd_in = n_ff;
            dvs_in = d_ff;
         end
      endcase
      rr_sh = {rr_ff[WIDE_W-2:0], dvd_ff[WIDE_W-1]};
      dsub = {1'b0, rr_sh} - {1'b0, dvs_ff};
      rr_in = dsub[WIDE_W] ? rr_sh : dsub[WIDE_W-1:0];
      qq_in = {qq_ff[WIDE_W-2:0], !dsub[WIDE_W]};
   end

   // Final formatting.
   logic negf, ovf;
   logic [WORD_W-1:0] q_lo, r_lo;

   assign negf = neg_ff && (n_ff != '0);
   assign ovf = (d_ff > LIM) || (q_ff > (LIM + WIDE_W'(negf)));
   assign q_lo = q_ff[WORD_W-1:0];
   assign r_lo = r_ff[WORD_W-1:0];

   logic signed [WORD_W-1:0] res_whole_ff, res_num_ff;
   logic [DEN_W-1:0] res_den_ff;
   logic [ST_W-1:0] res_st_ff;

   assign res_whole = res_whole_ff;
   assign res_num = res_num_ff;
   assign res_den = res_den_ff;
   assign status = res_st_ff;

   assign sts.err = (status_ff != ST_OK);
   assign sts.mul_done = mul_done_ff;
   assign sts.gcd_done = gcd_done_ff;
   assign sts.div_done = div_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_busy_ff <= 1'b0;
         mul_done_ff <= 1'b0;
         gph_ff <= G_IDLE;
         gcd_done_ff <= 1'b0;
         div_busy_ff <= 1'b0;
         div_done_ff <= 1'b0;
         status_ff <= ST_OK;
      end else begin
         mul_done_ff <= 1'b0;
         gcd_done_ff <= 1'b0;
         div_done_ff <= 1'b0;

         if (cmd.load) begin
            act_ff <= action;
            a_wm_ff <= a_wm_in;
            a_nm_ff <= a_nm_in;
            a_dm_ff <= a_dm_in;
            b_wm_ff <= b_wm_in;
            b_nm_ff <= b_nm_in;
            b_dm_ff <= b_dm_in;
            a_neg_ff <= a_neg_in;
            b_neg_ff <= b_neg_in;
            status_ff <= load_st;
         end

         if (cmd.mul_start) begin
            op1_ff <= op1_in;
            op2_ff <= op2_in;
            msel_ff <= cmd.mul_sel;
            acc_ff <= '0;
            step_ff <= 2'd0;
            mul_busy_ff <= 1'b1;
         end else if (mul_busy_ff) begin
            acc_ff <= acc_in;
            step_ff <= step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               mul_busy_ff <= 1'b0;
               mul_done_ff <= 1'b1;
               case (msel_ff)
                  MS_OPA: begin
                     a_mag_ff <= (a_wm_ff != '0) ? acc_in[MAG_W-1:0] + MAG_W'(a_nm_ff)
                                                 : MAG_W'(a_nm_ff);
                  end
                  MS_OPB: begin
                     b_mag_ff <= (b_wm_ff != '0) ? acc_in[MAG_W-1:0] + MAG_W'(b_nm_ff)
                                                 : MAG_W'(b_nm_ff);
                  end
                  MS_P1: x_ff <= acc_in;
                  MS_P2: y_ff <= acc_in;
                  default: z_ff <= acc_in;
               endcase
            end
         end

         if (cmd.combine) begin
            case (act_ff)
               ACT_ADD, ACT_SUB: begin
                  d_ff <= z_ff;
                  if (a_neg_ff == yneg) begin
                     n_ff <= x_ff + y_ff;
                     neg_ff <= a_neg_ff;
                  end else if (!diff[WIDE_W]) begin
                     n_ff <= diff[WIDE_W-1:0];
                     neg_ff <= a_neg_ff;
                  end else begin
                     n_ff <= ~diff[WIDE_W-1:0] + WIDE_W'(1);
                     neg_ff <= yneg;
                  end
               end
               ACT_MUL: begin
                  n_ff <= x_ff;
                  d_ff <= z_ff;
                  neg_ff <= a_neg_ff ^ b_neg_ff;
               end
               ACT_DIV: begin
                  n_ff <= x_ff;
                  d_ff <= y_ff;
                  neg_ff <= a_neg_ff ^ b_neg_ff;
                  if (y_ff == '0) begin
                     status_ff <= (x_ff == '0) ? ST_ZERO_ZERO : ST_ZERO_DEN;
                  end
               end
               default: begin
                  n_ff <= WIDE_W'(a_mag_ff);
                  d_ff <= WIDE_W'(a_dm_ff);
                  neg_ff <= a_neg_ff;
               end
            endcase
         end

         if (cmd.gcd_start) begin
            if (n_ff == '0) begin
               g_ff <= d_ff;
               gcd_done_ff <= 1'b1;
               gph_ff <= G_IDLE;
            end else begin
               ga_ff <= n_ff;
               gb_ff <= d_ff;
               k_ff <= '0;
               gph_ff <= G_COMMON;
            end
         end else begin
            case (gph_ff)
               G_COMMON: begin
                  if (!ga_ff[0] && !gb_ff[0]) begin
                     ga_ff <= ga_ff >> 1;
                     gb_ff <= gb_ff >> 1;
                     k_ff <= k_ff + CNT_W'(1);
                  end else begin
                     gph_ff <= G_AEVEN;
                  end
               end
               G_AEVEN: begin
                  if (!ga_ff[0]) begin
                     ga_ff <= ga_ff >> 1;
                  end else begin
                     gph_ff <= G_LOOP;
                  end
               end
               G_LOOP: begin
                  if (gb_ff == '0) begin
                     g_ff <= ga_ff << k_ff;
                     gcd_done_ff <= 1'b1;
                     gph_ff <= G_IDLE;
                  end else if (!gb_ff[0]) begin
                     gb_ff <= gb_ff >> 1;
                  end else if (gdiff[WIDE_W]) begin
                     ga_ff <= gb_ff;
                     gb_ff <= ~gdiff[WIDE_W-1:0] + WIDE_W'(1);
                  end else begin
                     gb_ff <= gdiff[WIDE_W-1:0];
                  end
               end
               default: begin
                  gph_ff <= G_IDLE;
               end
            endcase
         end

         if (cmd.div_start) begin
            dvd_ff <= dvd_in;
            dvs_ff <= dvs_in;
            rr_ff <= '0;
            qq_ff <= '0;
            cnt_ff <= '0;
            dsel_ff <= cmd.div_sel;
            div_busy_ff <= 1'b1;
         end else if (div_busy_ff) begin
            dvd_ff <= dvd_ff << 1;
            rr_ff <= rr_in;
            qq_ff <= qq_in;
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == {CNT_W{1'b1}}) begin
               div_busy_ff <= 1'b0;
               div_done_ff <= 1'b1;
               case (dsel_ff)
                  DS_NG: n_ff <= qq_in;
                  DS_DG: d_ff <= qq_in;
                  default: begin
                     q_ff <= qq_in;
                     r_ff <= rr_in;
                  end
               endcase
            end
         end

         if (cmd.finish) begin
            if (status_ff != ST_OK || ovf) begin
               res_whole_ff <= '0;
               res_num_ff <= '0;
               res_den_ff <= '0;
               res_st_ff <= (status_ff != ST_OK) ? status_ff : ST_OVERFLOW;
            end else begin
               res_st_ff <= ST_OK;
               res_den_ff <= d_ff[DEN_W-1:0];
               if (q_lo != '0 || q_ff != '0) begin
                  res_whole_ff <= negf ? (~q_lo + WORD_W'(1)) : q_lo;
                  res_num_ff <= r_lo;
               end else begin
                  res_whole_ff <= '0;
                  res_num_ff <= negf ? (~r_lo + WORD_W'(1)) : r_lo;
               end
            end
         end
      end
   end

endmodule

// File: rtl/mixed_fraction_alu.sv
// Top level of the mixed fraction ALU: request and response channels,
// controller and datapath. Depends on mfa_pkg, mfa_channels, mfa_controller, mfa_datapath.
//
// A request word carries an action and two mixed fractions; each request gives
// exactly one response word with a reduced proper mixed result and a status.
// Requests are taken one at a time: req_ch.ready is high only while the block
// is idle. When the operands fail the zero checks, the controller goes from
// S_MUL_GO straight to S_OUT, which registers the response; a division by a zero
// value goes to S_OUT from S_GCD_GO once the combine step has flagged it. A full
// item takes five multiplications on one shared 32x32 multiplier, a binary GCD over
// 128-bit values and three restoring divisions of 128-bit values; the run time per
// item is set mostly by the divider and the GCD loop.
// The response sits in an output register; a stalled receiver holds it there,
// and the block still takes and works on the next request, waiting only when
// that next result is ready to be written.
// Synchronous reset returns the block to idle with no response pending.
module mixed_fraction_alu #(
   parameter int VALUE_WIDTH = mfa_pkg::VALUE_WIDTH_DEF
) (
   input logic clock,
   input logic reset,
   mfa_req_if.sink req_ch,
   mfa_rsp_if.source rsp_ch
);
   import mfa_pkg::*;

   cmd_type cmd;
   sts_type sts;

   mfa_controller u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .rsp_valid(rsp_ch.valid),
      .rsp_ready(rsp_ch.ready),
      .cmd(cmd),
      .sts(sts)
   );

   mfa_datapath #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .sts(sts),
      .action(req_ch.action),
      .a_whole(req_ch.a_whole),
      .a_num(req_ch.a_num),
      .a_den(req_ch.a_den),
      .b_whole(req_ch.b_whole),
      .b_num(req_ch.b_num),
      .b_den(req_ch.b_den),
      .res_whole(rsp_ch.res_whole),
      .res_num(rsp_ch.res_num),
      .res_den(rsp_ch.res_den),
      .status(rsp_ch.status)
   );

endmodule
